@@ hw/rtl/kps_pkg.sv @@
package kps_pkg;

  // Keypad geometry
  localparam int ROWS = 4;
  localparam int COLS = 4;

  localparam int ROW_W  = 2;
  localparam int COL_W  = 2;
  localparam int KEY_W  = ROW_W + COL_W;
  localparam int CHAR_W = 8;
  localparam int CNT_W  = 8;

  localparam logic [COLS-1:0]  COL_MASK = {COLS{1'b1}};
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEYPAD_ENABLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_MAP_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_MAP_HIGH   = 3'd5;

  localparam logic [CNT_W-1:0] DEBOUNCE_TICKS_RST = 8'd20;

  typedef enum logic [2:0] {
    PH_SCAN    = 3'b001,
    PH_WAIT    = 3'b010,
    PH_RELEASE = 3'b100
  } kps_phase_t;

  typedef struct packed {
    logic [CNT_W-1:0]      debounce_ticks;
    logic                  debounce_enable;
    logic                  active_level;
    logic                  keypad_enable;
    logic [CFG_DATA_W-1:0] char_map_low;
    logic [CFG_DATA_W-1:0] char_map_high;
  } kps_cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row_select;
    logic              key_valid;
    logic [ROW_W-1:0]  key_row;
    logic [COL_W-1:0]  key_col;
    logic [CHAR_W-1:0] key_char;
  } kps_result_t;

endpackage

@@ hw/rtl/kps_in_if.sv @@
interface kps_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] col_sample;

  modport source (output valid, output col_sample, input ready);
  modport sink   (input valid, input col_sample, output ready);
endinterface

@@ hw/rtl/kps_out_if.sv @@
interface kps_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] row_select;
  logic       key_valid;
  logic [1:0] key_row;
  logic [1:0] key_col;
  logic [7:0] key_char;

  modport source (output valid, output row_select, output key_valid, output key_row,
                  output key_col, output key_char, input ready);
  modport sink   (input valid, input row_select, input key_valid, input key_row,
                  input key_col, input key_char, output ready);
endinterface

@@ hw/rtl/kps_cfg_regs.sv @@
module kps_cfg_regs
  import kps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output kps_cfg_t              cfg
);

  kps_cfg_t cfg_r;
  kps_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE_TICKS:  cfg_nxt.debounce_ticks  = cfg_wdata[CNT_W-1:0];
        REG_DEBOUNCE_ENABLE: cfg_nxt.debounce_enable = cfg_wdata[0];
        REG_ACTIVE_LEVEL:    cfg_nxt.active_level    = cfg_wdata[0];
        REG_KEYPAD_ENABLE:   cfg_nxt.keypad_enable   = cfg_wdata[0];
        REG_CHAR_MAP_LOW:    cfg_nxt.char_map_low    = cfg_wdata;
        REG_CHAR_MAP_HIGH:   cfg_nxt.char_map_high   = cfg_wdata;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks  <= DEBOUNCE_TICKS_RST;
      cfg_r.debounce_enable <= 1'b1;
      cfg_r.active_level    <= 1'b0;
      cfg_r.keypad_enable   <= 1'b1;
      cfg_r.char_map_low    <= '0;
      cfg_r.char_map_high   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/kps_scan_fsm.sv @@
module kps_scan_fsm
  import kps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic [3:0]  col_sample,
  input  kps_cfg_t    cfg,
  output kps_result_t res
);

  kps_phase_t       phase_r, phase_nxt;
  logic [ROW_W-1:0] scan_row_r, scan_row_nxt;
  logic [COL_W-1:0] held_col_r, held_col_nxt;
  logic [CNT_W-1:0] wait_count_r, wait_count_nxt;

  logic [COLS-1:0]   mask;
  logic              any_active;
  logic [COL_W-1:0]  low_col;
  logic              held_active;
  logic              valid;
  logic [ROW_W-1:0]  krow;
  logic [COL_W-1:0]  kcol;
  logic [ROW_W-1:0]  row_inc;
  logic [KEY_W-1:0]  key_num;
  logic [CFG_DATA_W-1:0] map_sel;

  // Pressed columns, at the configured active level
  always_comb begin
    mask = (cfg.active_level ? col_sample[COLS-1:0] : ~col_sample[COLS-1:0]) & COL_MASK;
    any_active = |mask;
    low_col = '0;
    for (int c = COLS - 1; c >= 0; c--) begin
      if (mask[c]) low_col = COL_W'(c);
    end
  end

  assign held_active = mask[held_col_r];
  assign row_inc     = (scan_row_r == LAST_ROW) ? '0 : scan_row_r + 1'b1;

  always_comb begin
    phase_nxt      = phase_r;
    scan_row_nxt   = scan_row_r;
    held_col_nxt   = held_col_r;
    wait_count_nxt = wait_count_r;
    valid          = 1'b0;
    krow           = '0;
    kcol           = '0;
    if (!cfg.keypad_enable) begin
      // drop any wait, keep the rows cycling
      phase_nxt    = PH_SCAN;
      scan_row_nxt = row_inc;
    end else begin
      case (phase_r)
        PH_WAIT: begin
          if (wait_count_r != '0) begin
            wait_count_nxt = wait_count_r - 1'b1;
          end else if (held_active) begin
            phase_nxt = PH_RELEASE;
          end else begin
            phase_nxt    = PH_SCAN;
            scan_row_nxt = '0;
          end
        end
        PH_RELEASE: begin
          if (!held_active) begin
            valid        = 1'b1;
            krow         = scan_row_r;
            kcol         = held_col_r;
            phase_nxt    = PH_SCAN;
            scan_row_nxt = '0;
          end
        end
        default: begin
          phase_nxt = PH_SCAN;
          if (any_active) begin
            if (cfg.debounce_enable) begin
              held_col_nxt   = low_col;
              wait_count_nxt = cfg.debounce_ticks;
              phase_nxt      = PH_WAIT;
            end else begin
              valid        = 1'b1;
              krow         = scan_row_r;
              kcol         = low_col;
              scan_row_nxt = '0;
            end
          end else begin
            scan_row_nxt = row_inc;
          end
        end
      endcase
    end
  end

  // Key number is row * COLS + col; byte of the matching map word
  always_comb begin
    key_num = KEY_W'(krow * COLS) + KEY_W'(kcol);
    map_sel = key_num[KEY_W-1] ? cfg.char_map_high : cfg.char_map_low;
  end

  always_comb begin
    res.row_select = scan_row_nxt;
    res.key_valid  = valid;
    res.key_row    = krow;
    res.key_col    = kcol;
    res.key_char   = valid ? map_sel[key_num[KEY_W-2:0]*CHAR_W +: CHAR_W] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SCAN;
      scan_row_r   <= '0;
      held_col_r   <= '0;
      wait_count_r <= '0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      scan_row_r   <= scan_row_nxt;
      held_col_r   <= held_col_nxt;
      wait_count_r <= wait_count_nxt;
    end
  end

endmodule

@@ hw/rtl/matrix_keypad_scan_debounce_core.sv @@
// 4x4 matrix keypad scanner with debounce.
//
// Input channel in_ch: one beat per scan tick, carrying col_sample, the column
// levels seen while the row from the previous row_select was driven.
// Result channel out_ch: exactly one beat per input beat, in order, with the
// row to drive next (row_select) and, when key_valid is high, the reported
// key's row, column and mapped character (all zero otherwise).
// Configuration: cfg_we/cfg_index/cfg_wdata write one register per cycle;
// write only while no beat is in flight.
//
// Path: a beat accepted on in_ch is held in the input register, then passes
// through the scan step into the result register.
// Throughput: one beat per cycle while out_ch.ready stays high; the scan state
// updates on every step, so back-to-back ticks flow without bubbles.
// Stall: while out_ch.ready is low the result register holds its beat and the
// input register can still take one more beat; in_ch.ready then drops.
// Reset (rst_n low, synchronous): both channels empty, scanning at row 0,
// configuration registers at their default values.
module matrix_keypad_scan_debounce_core
  import kps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  kps_in_if.sink                in_ch,
  kps_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  kps_cfg_t    cfg;
  kps_result_t step_res;

  logic        in_valid_r, in_valid_nxt;
  logic [3:0]  in_col_r;
  logic        out_valid_r, out_valid_nxt;
  kps_result_t out_res_r;

  logic        in_take;
  logic        advance;

  kps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Advance the held tick into the result register whenever it has room
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  kps_scan_fsm u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (advance),
    .col_sample (in_col_r),
    .cfg        (cfg),
    .res        (step_res)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load only on a beat, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_col_r <= in_ch.col_sample;
    end
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.row_select = out_res_r.row_select;
  assign out_ch.key_valid  = out_res_r.key_valid;
  assign out_ch.key_row    = out_res_r.key_row;
  assign out_ch.key_col    = out_res_r.key_col;
  assign out_ch.key_char   = out_res_r.key_char;

endmodule

@@ test/matrix_keypad_scan_debounce_core_tb.sv @@
`timescale 1ns / 1ps

module matrix_keypad_scan_debounce_core_tb
  import kps_pkg::*;
();

  // Tracks the scanner's state and configuration beat by beat and holds the
  // result beats still to come, oldest first.
  class keypad_tracker;
    kps_cfg_t         cfg;
    logic [ROW_W-1:0] row;
    kps_phase_t       ph;
    logic [COL_W-1:0] held;
    logic [CNT_W-1:0] cnt;
    kps_result_t      due_beats[$];
    int               errors;
    int               checked;
    int               keys_seen;

    function new();
      cfg.debounce_ticks  = DEBOUNCE_TICKS_RST;
      cfg.debounce_enable = 1'b1;
      cfg.active_level    = 1'b0;
      cfg.keypad_enable   = 1'b1;
      cfg.char_map_low    = '0;
      cfg.char_map_high   = '0;
      row    = '0;
      ph     = PH_SCAN;
      held   = '0;
      cnt    = '0;
      errors = 0;
      checked = 0;
      keys_seen = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DEBOUNCE_TICKS:  cfg.debounce_ticks  = data[CNT_W-1:0];
        REG_DEBOUNCE_ENABLE: cfg.debounce_enable = data[0];
        REG_ACTIVE_LEVEL:    cfg.active_level    = data[0];
        REG_KEYPAD_ENABLE:   cfg.keypad_enable   = data[0];
        REG_CHAR_MAP_LOW:    cfg.char_map_low    = data;
        REG_CHAR_MAP_HIGH:   cfg.char_map_high   = data;
        default: ;
      endcase
    endfunction

    function logic [ROW_W-1:0] next_row(logic [ROW_W-1:0] r);
      return (r == LAST_ROW) ? '0 : r + 1'b1;
    endfunction

    function logic [CHAR_W-1:0] char_of(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
      logic [KEY_W-1:0] n;
      n = {r, c};
      if (n[3]) return cfg.char_map_high[n[2:0]*8 +: 8];
      return cfg.char_map_low[n[2:0]*8 +: 8];
    endfunction

    // One scan tick: advance the state and build the result beat.
    function kps_result_t scan_step(logic [3:0] col);
      logic [COLS-1:0] act;
      logic [COL_W-1:0] c;
      kps_result_t r;
      act = (cfg.active_level ? col : ~col) & COL_MASK;
      r = '0;
      if (!cfg.keypad_enable) begin
        ph  = PH_SCAN;
        row = next_row(row);
      end else begin
        case (ph)
          PH_WAIT: begin
            if (cnt != 0) begin
              cnt = cnt - 1'b1;
            end else if (act[held]) begin
              ph = PH_RELEASE;
            end else begin
              ph  = PH_SCAN;
              row = '0;
            end
          end
          PH_RELEASE: begin
            if (!act[held]) begin
              r.key_valid = 1'b1;
              r.key_row   = row;
              r.key_col   = held;
              r.key_char  = char_of(row, held);
              ph  = PH_SCAN;
              row = '0;
            end
          end
          default: begin
            ph = PH_SCAN;
            if (act != 0) begin
              c = act[0] ? 2'd0 : act[1] ? 2'd1 : act[2] ? 2'd2 : 2'd3;
              if (cfg.debounce_enable) begin
                held = c;
                cnt  = cfg.debounce_ticks;
                ph   = PH_WAIT;
              end else begin
                r.key_valid = 1'b1;
                r.key_row   = row;
                r.key_col   = c;
                r.key_char  = char_of(row, c);
                row = '0;
              end
            end else begin
              row = next_row(row);
            end
          end
        endcase
      end
      r.row_select = row;
      return r;
    endfunction

    function void note_tick(logic [3:0] col);
      due_beats.push_back(scan_step(col));
    endfunction

    function int pending();
      return due_beats.size();
    endfunction

    task report(string what, int got, int want);
      errors++;
      $display("mismatch %0s: got %0d, expected %0d (result %0d)", what, got, want, checked);
    endtask

    task check_beat(kps_result_t got);
      kps_result_t want;
      if (due_beats.size() == 0) begin
        report("result beat with nothing outstanding", 0, 0);
        return;
      end
      want = due_beats.pop_front();
      if (got.row_select !== want.row_select) report("row_select", got.row_select, want.row_select);
      if (got.key_valid !== want.key_valid) report("key_valid", got.key_valid, want.key_valid);
      if (got.key_row !== want.key_row) report("key_row", got.key_row, want.key_row);
      if (got.key_col !== want.key_col) report("key_col", got.key_col, want.key_col);
      if (got.key_char !== want.key_char) report("key_char", got.key_char, want.key_char);
      if (want.key_valid) keys_seen++;
      checked++;
    endtask
  endclass

  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_OFF_LEN = 64;
  localparam int NUM_PHASES   = 12;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  kps_in_if  in_ch();
  kps_out_if out_ch();

  keypad_tracker tracker = new();

  int   idle_cycles = 0;
  int   ticks_sent = 0;
  bit   no_idle = 1'b0;
  bit   hold_off_req = 1'b0;
  bit   held_off = 1'b0;
  logic [15:0] keys_down = '0;   // virtual keypad, bit row*COLS+col

  matrix_keypad_scan_debounce_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: end the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("FAIL matrix_keypad_scan_debounce_core");
      $finish;
    end
  end

  // Offer one tick; hold the beat until the block takes it, then note it.
  task automatic send_tick(input logic [3:0] col);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.col_sample <= col;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_tick(col);
    ticks_sent++;
  endtask

  // Column levels of the virtual keypad for the row the block now drives.
  function automatic logic [3:0] keypad_levels();
    logic [3:0] pressed;
    pressed = keys_down[{tracker.row, 2'b00} +: 4];
    return tracker.cfg.active_level ? pressed : ~pressed;
  endfunction

  // Write one register; leave the write enable high so back-to-back writes
  // do not drop it within a step. Callers lower it after the group.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.set_reg(idx, data);
  endtask

  // Drop valid and wait until every outstanding result beat has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [CNT_W-1:0] ticks, input logic deb_en,
                           input logic level, input logic kp_en,
                           input logic [63:0] map_lo, input logic [63:0] map_hi);
    drain();
    write_reg(REG_DEBOUNCE_TICKS, 64'(ticks));
    write_reg(REG_DEBOUNCE_ENABLE, 64'(deb_en));
    write_reg(REG_ACTIVE_LEVEL, 64'(level));
    write_reg(REG_KEYPAD_ENABLE, 64'(kp_en));
    write_reg(REG_CHAR_MAP_LOW, map_lo);
    write_reg(REG_CHAR_MAP_HIGH, map_hi);
    cfg_we <= 1'b0;
  endtask

  // Mostly clean presses held around the debounce time, then releases;
  // sprinkle bounce noise and the odd double press on top.
  task automatic run_keypad(input int n_ticks);
    int hold;
    logic [3:0] col;
    hold = 0;
    keys_down = '0;
    for (int i = 0; i < n_ticks; i++) begin
      if (hold == 0) begin
        if (keys_down != 0 || $urandom_range(0, 3) == 0) begin
          keys_down = '0;
          hold = $urandom_range(1, 4);
        end else begin
          keys_down = 16'h1 << $urandom_range(0, 15);
          if ($urandom_range(0, 5) == 0) keys_down |= 16'h1 << $urandom_range(0, 15);
          hold = $urandom_range(1, int'(tracker.cfg.debounce_ticks) + 10);
        end
      end
      hold--;
      col = keypad_levels();
      if ($urandom_range(0, 9) == 0) col = 4'($urandom_range(0, 15));
      send_tick(col);
    end
  endtask

  // Result side: stall at random, once for a long stretch on request.
  initial begin
    int gap;
    kps_result_t got;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req && !held_off) begin
        // hold off long enough for the block to fill and stall its input
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(posedge clk);
        held_off = 1'b1;
      end
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got.row_select = out_ch.row_select;
      got.key_valid  = out_ch.key_valid;
      got.key_row    = out_ch.key_row;
      got.key_col    = out_ch.key_col;
      got.key_char   = out_ch.key_char;
      tracker.check_beat(got);
    end
  end

  initial begin
    logic [CNT_W-1:0] ticks;
    logic [63:0] map_lo, map_hi;
    int n_ticks;
    in_ch.valid      <= 1'b0;
    in_ch.col_sample <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: immediate reports, active low, all-idle and all-pressed lines.
    configure(8'd0, 1'b0, 1'b0, 1'b1, 64'hA7A6A5A4A3A2A1A0, 64'hAFAEADACABAAA9A8);
    send_tick(4'hF);
    send_tick(4'h0);
    send_tick(4'h7);
    send_tick(4'hE);
    send_tick(4'hF);
    send_tick(4'hF);
    send_tick(4'hF);
    send_tick(4'hB);
    // Zero debounce ticks: detect, resample next tick, hold, release.
    configure(8'd0, 1'b1, 1'b0, 1'b1, 64'hA7A6A5A4A3A2A1A0, 64'hAFAEADACABAAA9A8);
    send_tick(4'hE);
    send_tick(4'hE);
    send_tick(4'hE);
    send_tick(4'hF);
    // bounce: gone at resample, scanning resumes
    send_tick(4'hD);
    send_tick(4'hF);
    // Active high, highest column on the highest row.
    configure(8'd1, 1'b1, 1'b1, 1'b1, 64'hFFFFFFFFFFFFFFFF, 64'h0123456789ABCDEF);
    send_tick(4'h0);
    send_tick(4'h0);
    send_tick(4'h0);
    send_tick(4'h8);
    send_tick(4'hF);
    send_tick(4'h8);
    send_tick(4'h8);
    send_tick(4'h0);
    // Keypad off while the block may still be holding a wait.
    send_tick(4'h1);
    configure(8'd1, 1'b1, 1'b1, 1'b0, 64'hFFFFFFFFFFFFFFFF, 64'h0123456789ABCDEF);
    send_tick(4'hF);
    send_tick(4'h0);

    // Random phases over a spread of settings, extremes first.
    for (int p = 0; p < NUM_PHASES; p++) begin
      ticks  = (p == 0) ? 8'd0 : (p == 1) ? 8'd255 : (p == 2) ? 8'd1 :
               8'($urandom_range(0, 6));
      map_lo = (p == 0) ? 64'h0 : (p == 2) ? '1 : {$urandom, $urandom};
      map_hi = (p == 0) ? 64'h0 : (p == 2) ? '1 : {$urandom, $urandom};
      configure(ticks, (p % 4) != 3, p[0], (p != 5) && (p != 9 || $urandom_range(0, 1)),
                map_lo, map_hi);
      no_idle = (p == 4 || p == 8);
      if (p == 6) hold_off_req = 1'b1;
      n_ticks = (p == 1) ? 300 : 80;
      run_keypad(n_ticks);
    end

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d scan ticks over %0d settings, %0d result beats checked,",
             ticks_sent, NUM_PHASES + 4, tracker.checked);
    $display("%0d key reports among them, %0d mismatches", tracker.keys_seen,
             tracker.errors);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS matrix_keypad_scan_debounce_core");
    end else begin
      $display("FAIL matrix_keypad_scan_debounce_core");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/kps_pkg.sv
hw/rtl/kps_in_if.sv
hw/rtl/kps_out_if.sv
hw/rtl/kps_cfg_regs.sv
hw/rtl/kps_scan_fsm.sv
hw/rtl/matrix_keypad_scan_debounce_core.sv
test/matrix_keypad_scan_debounce_core_tb.sv
